// ----- rtl/ppe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppe_pkg
// shared widths, controller/datapath interface types and exponent saturation
// ----------------------------------------------------------------------------
package ppe_pkg;

    // width of the tested integer
    localparam int VALUE_WIDTH      = 32;
    // widest base ever tried: floor(sqrt(2^(VALUE_WIDTH-1))) + 1
    localparam int BASE_WIDTH       = (VALUE_WIDTH + 1) / 2;
    // exact power times base
    localparam int PROD_WIDTH       = VALUE_WIDTH + BASE_WIDTH;
    // largest exponent reached is VALUE_WIDTH-1
    localparam int POW_CNT_WIDTH    = $clog2(VALUE_WIDTH);
    localparam int EXP_WIDTH        = 5;
    localparam logic [EXP_WIDTH-1:0] EXP_MAX = '1;
    localparam logic [EXP_WIDTH-1:0] EXP_NONE = EXP_WIDTH'(1);

    localparam int IN_TDATA_WIDTH   = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH  = ((EXP_WIDTH + 7) / 8) * 8;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture value, start at base 2
        logic take_prod;   // power <= power * base, exponent + 1
        logic next_base;   // base + 1, power <= base, exponent <= 1
        logic mark_found;  // current exponent is the answer
        logic out_load;    // write result into the output register
    } ppe_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic prod_gt_mag; // power * base passes |value|
        logic pw_ge_mag;   // power has reached |value|
        logic hit_ok;      // power equals |value| with a usable exponent
    } ppe_status_t;

    function automatic logic [EXP_WIDTH-1:0] sat_exponent(
        input logic [POW_CNT_WIDTH-1:0] p
    );
        logic [EXP_WIDTH-1:0] r;
        if (32'(p) > 32'(EXP_MAX)) begin
            r = EXP_MAX;
        end else begin
            r = EXP_WIDTH'(p);
        end
        return r;
    endfunction

endpackage : ppe_pkg
`default_nettype wire

// ----- rtl/perfect_power_exponent_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// perfect_power_exponent_core
// largest exponent p with value = b^p for an integer base b, 1 if none
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata bits (low first)          | tuser / tlast
//  ---------+-----+---------------------------------+--------------
//  s_axis   | in  | value [VALUE_WIDTH-1:0], signed | none
//  m_axis   | out | exponent [4:0], zero pad above  | none
//
//  sequence: one transaction at a time; after acceptance each base has its
//    square tested, then its powers are raised one at a time from the
//    square up to |value| by the single power-times-base multiplier
//  values with |value| < 4 stop at the first square test
//  reset: aresetn low clears the sequencer and the output valid flag;
//    s_axis_tready stays low while reset is held
//  stalls: the result waits in an output register, so a new transaction is
//    taken while m_axis_tready is low; only the next result waits for it
//
// ----------------------------------------------------------------------------
module perfect_power_exponent_core
    import ppe_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // value
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
    // exponent
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [OUT_TDATA_WIDTH-1:0]      m_axis_tdata
);

    ppe_cmd_t             cmd;
    ppe_status_t          status;
    logic [EXP_WIDTH-1:0] exponent;

    // sequencer: search order and result handoff
    ppe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // bits above the value width are ignored
    ppe_datapath u_datapath (
        .aclk     (aclk),
        .value    (s_axis_tdata[VALUE_WIDTH-1:0]),
        .cmd      (cmd),
        .status   (status),
        .exponent (exponent)
    );

    assign m_axis_tdata = OUT_TDATA_WIDTH'(exponent);

endmodule : perfect_power_exponent_core
`default_nettype wire

// ----- rtl/ppe_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppe_datapath
// magnitude, base, running power and exponent registers around one multiplier
// ----------------------------------------------------------------------------
module ppe_datapath
    import ppe_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire ppe_cmd_t               cmd,
    output ppe_status_t                 status,
    output logic [EXP_WIDTH-1:0]        exponent
);

    logic                     neg_reg;
    logic [VALUE_WIDTH-1:0]   mag_reg;
    logic [BASE_WIDTH-1:0]    b_reg;
    logic [VALUE_WIDTH-1:0]   pw_reg;
    logic [POW_CNT_WIDTH-1:0] p_reg;
    logic                     found_reg;
    logic [EXP_WIDTH-1:0]     exp_reg;

    logic [VALUE_WIDTH-1:0]   mag_in;
    logic [PROD_WIDTH-1:0]    prod;
    logic [BASE_WIDTH-1:0]    b_inc;

    // two's complement magnitude, most negative value maps to 2^(W-1)
    assign mag_in = value[VALUE_WIDTH-1] ? VALUE_WIDTH'(~value + VALUE_WIDTH'(1)) : value;

    assign prod  = PROD_WIDTH'(pw_reg) * PROD_WIDTH'(b_reg);
    assign b_inc = b_reg + BASE_WIDTH'(1);

    assign status.prod_gt_mag = prod > PROD_WIDTH'(mag_reg);
    assign status.pw_ge_mag   = pw_reg >= mag_reg;
    // negative values only match at odd exponents
    assign status.hit_ok      = (pw_reg == mag_reg) && (!neg_reg || p_reg[0]);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg   <= value[VALUE_WIDTH-1];
            mag_reg   <= mag_in;
            b_reg     <= BASE_WIDTH'(2);
            pw_reg    <= VALUE_WIDTH'(2);
            p_reg     <= POW_CNT_WIDTH'(1);
            found_reg <= 1'b0;
        end else if (cmd.take_prod) begin
            pw_reg    <= prod[VALUE_WIDTH-1:0];
            p_reg     <= p_reg + POW_CNT_WIDTH'(1);
        end else if (cmd.next_base) begin
            b_reg     <= b_inc;
            pw_reg    <= VALUE_WIDTH'(b_inc);
            p_reg     <= POW_CNT_WIDTH'(1);
        end
        if (cmd.mark_found) begin
            found_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            exp_reg <= found_reg ? sat_exponent(p_reg) : EXP_NONE;
        end
    end

    assign exponent = exp_reg;

endmodule : ppe_datapath
`default_nettype wire

// ----- rtl/ppe_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppe_ctrl
// sequencer for the base / power search and the output valid flag
// ----------------------------------------------------------------------------
module ppe_ctrl
    import ppe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire ppe_status_t status,
    output ppe_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_RAISE  = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = aresetn && (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                // base squared past |value|: no base left, answer stays 1
                if (status.prod_gt_mag) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.take_prod = 1'b1;
                    state_next    = ST_RAISE;
                end
            end
            ST_RAISE: begin
                if (status.pw_ge_mag) begin
                    if (status.hit_ok) begin
                        cmd.mark_found = 1'b1;
                        state_next     = ST_DONE;
                    end else begin
                        cmd.next_base = 1'b1;
                        state_next    = ST_SQUARE;
                    end
                end else if (status.prod_gt_mag) begin
                    cmd.next_base = 1'b1;
                    state_next    = ST_SQUARE;
                end else begin
                    cmd.take_prod = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule : ppe_ctrl
`default_nettype wire

// ----- rtl/ppe_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppe_checker
// port-level checks on the core, bound to the top level
// ----------------------------------------------------------------------------
module ppe_checker
    import ppe_pkg::*;
(
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

    logic s_xact;
    assign s_xact = s_axis_tvalid && s_axis_tready;

    // one transaction in work at a time
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_xact |=> !s_axis_tready
    ) else $error("input taken twice in a row");

    // exponent is 1..31 with zero padding
    a_result_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[EXP_WIDTH-1:0] != '0) &&
                          ((m_axis_tdata >> EXP_WIDTH) == '0)
    ) else $error("exponent out of range");

    // a fresh result only comes out of a search in progress
    a_result_from_search: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready)
    ) else $error("result without a search");

    a_out_hold: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    ) else $error("stalled result changed");

endmodule : ppe_checker

bind perfect_power_exponent_core ppe_checker u_ppe_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
